/* sv/trie_insert_lookup_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the trie insert and lookup block
// Clocked assertion forms shared by the checker.
// ----------------------------------------------------------------------------
`ifndef TRIE_INSERT_LOOKUP_TOP_MACROS_SVH
`define TRIE_INSERT_LOOKUP_TOP_MACROS_SVH

// checked only outside reset
`define TRIE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TRIE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/trie_pkg.sv */
// ----------------------------------------------------------------------------
// trie_pkg
// Types, constants and helper functions for the trie insert and lookup block.
// ----------------------------------------------------------------------------
package trie_pkg;

    localparam int unsigned DEF_MAX_NODES     = 128;
    localparam int unsigned DEF_ALPHABET_SIZE = 256;
    localparam logic [7:0]  LIMIT_RESET       = 8'd128;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EDGE,
        S_END,
        S_MARK,
        S_EMIT
    } t_state;

    typedef logic [255:0][7:0] t_sym_map;

    // symbol reduced modulo the alphabet size, built by counting
    function automatic t_sym_map sym_mod_table(input int unsigned a);
        t_sym_map   tab;
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < 256; i++) begin
            tab[i] = r;
            r = ((32'(r) + 32'd1) == a) ? 8'd0 : r + 8'd1;
        end
        return tab;
    endfunction

endpackage

/* sv/trie_edge_ram.sv */
// ----------------------------------------------------------------------------
// trie_edge_ram
// Node-by-symbol transition table, one write and one registered read port.
// ----------------------------------------------------------------------------
module trie_edge_ram #(
    parameter int unsigned DEPTH = 32768,
    parameter int unsigned AW    = 15,
    parameter int unsigned DW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/trie_mark_ram.sv */
// ----------------------------------------------------------------------------
// trie_mark_ram
// Word-end mark per node, one write and one registered read port.
// ----------------------------------------------------------------------------
module trie_mark_ram #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic          i_wdata,
    output logic          o_rdata
);

    logic mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/trie_ctrl.sv */
// ----------------------------------------------------------------------------
// trie_ctrl
// Sequencer: clearing pass, edge read and write-back, word-end marking,
// node allocation and the output register.
// ----------------------------------------------------------------------------
module trie_ctrl
    import trie_pkg::*;
#(
    parameter int unsigned MAX_NODES     = DEF_MAX_NODES,
    parameter int unsigned ALPHABET_SIZE = DEF_ALPHABET_SIZE,
    parameter int unsigned NODE_W        = $clog2(MAX_NODES),
    parameter int unsigned EDGE_DEPTH    = MAX_NODES * ALPHABET_SIZE,
    parameter int unsigned EDGE_AW       = $clog2(EDGE_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_opcode,
    input  logic [7:0]         i_symbol,
    input  logic               i_last_symbol,
    input  logic               i_empty_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [7:0]         o_nodes_used,
    output logic               o_edge_we,
    output logic               o_edge_re,
    output logic [EDGE_AW-1:0] o_edge_addr,
    output logic [NODE_W-1:0]  o_edge_wdata,
    input  logic [NODE_W-1:0]  i_edge_rdata,
    output logic               o_mark_we,
    output logic               o_mark_re,
    output logic [NODE_W-1:0]  o_mark_addr,
    output logic               o_mark_wdata,
    input  logic               i_mark_rdata
);

    localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
    localparam int unsigned LIM_W = (CNT_W > 8) ? CNT_W : 8;
    localparam t_sym_map    SYM_MAP = sym_mod_table(ALPHABET_SIZE);

    t_state             r_state, n_state;
    logic [EDGE_AW-1:0] r_clr, n_clr;
    logic [NODE_W-1:0]  r_cur, n_cur;
    logic [NODE_W-1:0]  r_node, n_node;
    logic               r_failed, n_failed;
    logic [CNT_W-1:0]   r_next_free, n_next_free;
    logic [7:0]         r_limit, n_limit;
    logic               r_op, n_op;
    logic               r_last, n_last;
    logic [EDGE_AW-1:0] r_addr, n_addr;
    t_status            r_status, n_status;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [7:0]         r_out_nodes, n_out_nodes;

    logic [EDGE_AW-1:0] in_addr;
    logic [LIM_W-1:0]   nf_ext, lim_ext, max_ext, act_lim;
    logic               full;
    logic               can_load;

    assign in_addr = EDGE_AW'(EDGE_AW'(r_cur) * EDGE_AW'(ALPHABET_SIZE))
                   + EDGE_AW'(SYM_MAP[i_symbol]);

    assign nf_ext   = LIM_W'(r_next_free);
    assign lim_ext  = LIM_W'(r_limit);
    assign max_ext  = LIM_W'(MAX_NODES);
    assign act_lim  = (lim_ext < max_ext) ? lim_ext : max_ext;
    assign full     = nf_ext >= act_lim;
    assign can_load = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cur       <= '0;
            r_failed    <= 1'b0;
            r_next_free <= CNT_W'(1);
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cur       <= n_cur;
            r_failed    <= n_failed;
            r_next_free <= n_next_free;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node       <= n_node;
        r_op         <= n_op;
        r_last       <= n_last;
        r_addr       <= n_addr;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_nodes  <= n_out_nodes;
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_cur        = r_cur;
        n_node       = r_node;
        n_failed     = r_failed;
        n_next_free  = r_next_free;
        n_limit      = i_cfg_we ? i_cfg_wdata : r_limit;
        n_op         = r_op;
        n_last       = r_last;
        n_addr       = r_addr;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_nodes  = r_out_nodes;
        o_in_ready   = 1'b0;
        o_edge_we    = 1'b0;
        o_edge_re    = 1'b0;
        o_edge_addr  = r_addr;
        o_edge_wdata = NODE_W'(r_next_free);
        o_mark_we    = 1'b0;
        o_mark_re    = 1'b0;
        o_mark_addr  = r_node;
        o_mark_wdata = 1'b1;

        unique case (r_state)
            S_CLEAR: begin
                o_edge_we    = 1'b1;
                o_edge_addr  = r_clr;
                o_edge_wdata = '0;
                o_mark_we    = 1'b1;
                o_mark_addr  = r_clr[NODE_W-1:0];
                o_mark_wdata = 1'b0;
                n_clr        = r_clr + EDGE_AW'(1);
                if (r_clr == EDGE_AW'(EDGE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op    = i_opcode;
                    n_last  = i_last_symbol;
                    n_addr  = in_addr;
                    n_node  = r_cur;
                    if (!i_empty_word && !r_failed) begin
                        o_edge_re   = 1'b1;
                        o_edge_addr = in_addr;
                        n_state     = S_EDGE;
                    end else if (i_last_symbol || i_empty_word) begin
                        n_state = S_END;
                    end
                end
            end
            S_EDGE: begin
                n_node = i_edge_rdata;
                if (i_edge_rdata == '0) begin
                    if (!r_op || full) begin
                        n_failed = 1'b1;
                        n_node   = r_cur;
                    end else begin
                        o_edge_we   = 1'b1;
                        n_node      = NODE_W'(r_next_free);
                        n_next_free = r_next_free + CNT_W'(1);
                    end
                end
                if (r_last) begin
                    n_state = S_END;
                end else begin
                    n_cur   = n_node;
                    n_state = S_IDLE;
                end
            end
            S_END: begin
                if (r_failed) begin
                    n_status = r_op ? ST_FULL : ST_MISS;
                    n_state  = S_EMIT;
                end else if (r_op) begin
                    o_mark_we = 1'b1;
                    n_status  = ST_OK;
                    n_state   = S_EMIT;
                end else begin
                    o_mark_re = 1'b1;
                    n_state   = S_MARK;
                end
            end
            S_MARK: begin
                n_status = i_mark_rdata ? ST_OK : ST_MISS;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (can_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_nodes  = 8'(r_next_free);
                    n_cur        = '0;
                    n_failed     = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_nodes_used = r_out_nodes;

endmodule

/* sv/trie_insert_lookup_top.sv */
// ----------------------------------------------------------------------------
// trie_insert_lookup_top
// Trie held as a node-by-symbol transition table with word-end marks.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one byte of a word per
// transaction with its opcode (0 lookup, 1 insert), a last-symbol flag and
// an empty-word flag. A result transaction (o_out_valid / i_out_ready) is
// produced for each item that ends a word: status and the node count.
// node_limit is written through i_cfg_we / i_cfg_wdata; the user writes it
// only while idle, and the block does not enforce this. An item is taken in
// S_IDLE. A byte of a live word then has its edge read in S_EDGE, with
// write-back of a newly allocated node on an insert miss; a byte of a failed
// word is only taken. A word end then passes S_END, which writes the mark for
// an insert or reads it in S_MARK for a lookup of a live word, and S_EMIT.
// o_out_valid rises together with o_in_ready when the result leaves S_EMIT.
// After reset a clearing pass writes zero over the whole edge table
// (MAX_NODES * ALPHABET_SIZE entries, 32768 by default) and the marks, with
// o_in_ready low; configuration writes are still taken.
// When the receiver stalls, a finished result waits in the output register;
// the next word's bytes are still taken, and only the next ending item
// waits until the register is free.
// ----------------------------------------------------------------------------
module trie_insert_lookup_top
    import trie_pkg::*;
#(
    parameter int unsigned MAX_NODES     = DEF_MAX_NODES,
    parameter int unsigned ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_opcode,
    input  logic [7:0] i_symbol,
    input  logic       i_last_symbol,
    input  logic       i_empty_word,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_status,
    output logic [7:0] o_nodes_used
);

    localparam int unsigned NODE_W     = $clog2(MAX_NODES);
    localparam int unsigned EDGE_DEPTH = MAX_NODES * ALPHABET_SIZE;
    localparam int unsigned EDGE_AW    = $clog2(EDGE_DEPTH);

    logic               edge_we, edge_re;
    logic [EDGE_AW-1:0] edge_addr;
    logic [NODE_W-1:0]  edge_wdata, edge_rdata;
    logic               mark_we, mark_re, mark_wdata, mark_rdata;
    logic [NODE_W-1:0]  mark_addr;

    trie_ctrl #(
        .MAX_NODES     (MAX_NODES),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .NODE_W        (NODE_W),
        .EDGE_DEPTH    (EDGE_DEPTH),
        .EDGE_AW       (EDGE_AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_symbol      (i_symbol),
        .i_last_symbol (i_last_symbol),
        .i_empty_word  (i_empty_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_nodes_used  (o_nodes_used),
        .o_edge_we     (edge_we),
        .o_edge_re     (edge_re),
        .o_edge_addr   (edge_addr),
        .o_edge_wdata  (edge_wdata),
        .i_edge_rdata  (edge_rdata),
        .o_mark_we     (mark_we),
        .o_mark_re     (mark_re),
        .o_mark_addr   (mark_addr),
        .o_mark_wdata  (mark_wdata),
        .i_mark_rdata  (mark_rdata)
    );

    trie_edge_ram #(
        .DEPTH (EDGE_DEPTH),
        .AW    (EDGE_AW),
        .DW    (NODE_W)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_re    (edge_re),
        .i_addr  (edge_addr),
        .i_wdata (edge_wdata),
        .o_rdata (edge_rdata)
    );

    trie_mark_ram #(
        .DEPTH (MAX_NODES),
        .AW    (NODE_W)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_re    (mark_re),
        .i_addr  (mark_addr),
        .i_wdata (mark_wdata),
        .o_rdata (mark_rdata)
    );

endmodule

/* sv/trie_chk.sv */
// ----------------------------------------------------------------------------
// trie_chk
// Port-level checks on the trie block, bound to the top level.
// ----------------------------------------------------------------------------
`include "trie_insert_lookup_top_macros.svh"

module trie_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_last_symbol,
    input logic       i_empty_word,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_status,
    input logic [7:0] o_nodes_used
);

    // clearing pass follows reset
    `TRIE_ASSERT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n |=> !o_in_ready, "ready during clear")

    // o_in_ready always drops after a word end is taken
    `TRIE_ASSERT(a_end_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_last_symbol || i_empty_word) |=> !o_in_ready, "ready after word end")

    `TRIE_ASSERT(a_status_code, i_clk, i_rst_n, o_out_valid |-> (o_status != 2'd3) && (o_nodes_used != 8'd0), "bad result")

    `TRIE_ASSERT(a_result_held, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) && $stable(o_nodes_used), "result dropped")

endmodule

bind trie_insert_lookup_top trie_chk u_chk (.*);

/* test/trie_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trie_checker
// Watches the configuration port and both channels of the trie block, keeps
// its own copy of the transition table, word-end marks and node counter, and
// compares every result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module trie_checker
    import trie_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_opcode,
    input  logic [7:0] i_symbol,
    input  logic       i_last_symbol,
    input  logic       i_empty_word,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_status,
    input  logic [7:0] i_nodes_used,
    output int         o_err_count,
    output int         o_pending
);

    localparam int unsigned NODES = DEF_MAX_NODES;
    localparam int unsigned ALPHA = DEF_ALPHABET_SIZE;

    typedef struct packed {
        t_status    status;
        logic [7:0] nodes_used;
    } t_word_result;

    logic [7:0]   edge_tbl [NODES][ALPHA];
    bit           word_end [NODES];
    int unsigned  free_node;
    int unsigned  cur_node;
    int unsigned  node_lim;
    bit           walk_failed;
    t_word_result word_results_q [$];
    int           err_cnt = 0;
    int           pend_cnt = 0;

    assign o_err_count = err_cnt;
    assign o_pending   = pend_cnt;

    task automatic clear_trie();
        for (int n = 0; n < NODES; n++) begin
            word_end[n] = 1'b0;
            for (int s = 0; s < ALPHA; s++) edge_tbl[n][s] = '0;
        end
        free_node   = 1;
        cur_node    = 0;
        walk_failed = 1'b0;
        node_lim    = LIMIT_RESET;
    endtask

    // one byte of a word; returns 1 when the byte ends the word
    function automatic bit walk_trie(input logic op, input logic [7:0] sym,
                                     input logic last, input logic empty,
                                     output t_word_result res);
        int unsigned node;
        int unsigned child;
        int unsigned eff_lim;
        eff_lim = (node_lim < NODES) ? node_lim : NODES;
        node    = (cur_node < NODES) ? cur_node : 0;
        res     = '0;
        if (!empty && !walk_failed) begin
            child = edge_tbl[node][int'(sym) % ALPHA];
            if (child == 0) begin
                if (!op || free_node >= eff_lim) begin
                    walk_failed = 1'b1;
                end else begin
                    child = free_node;
                    edge_tbl[node][int'(sym) % ALPHA] = 8'(child);
                    free_node++;
                end
            end
            if (!walk_failed && child < NODES) node = child;
        end
        cur_node = node;
        if (!(last || empty)) return 1'b0;
        if (walk_failed) begin
            res.status = op ? ST_FULL : ST_MISS;
        end else if (op) begin
            word_end[node] = 1'b1;
            res.status = ST_OK;
        end else begin
            res.status = word_end[node] ? ST_OK : ST_MISS;
        end
        res.nodes_used = 8'(free_node);
        cur_node    = 0;
        walk_failed = 1'b0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_word_result res;
        t_word_result exp;
        if (!i_rst_n) begin
            clear_trie();
            word_results_q.delete();
        end else begin
            if (i_cfg_we) node_lim = i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                if (walk_trie(i_opcode, i_symbol, i_last_symbol, i_empty_word, res))
                    word_results_q.push_back(res);
            end
            if (i_out_valid && i_out_ready) begin
                if (word_results_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected result transaction status=%0d nodes=%0d",
                                 $realtime, i_status, i_nodes_used);
                end else begin
                    exp = word_results_q.pop_front();
                    if (i_status !== exp.status || i_nodes_used !== exp.nodes_used) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("%0t: mismatch: status exp %0d got %0d, nodes exp %0d got %0d",
                                     $realtime, exp.status, i_status, exp.nodes_used,
                                     i_nodes_used);
                    end
                end
            end
        end
        pend_cnt = word_results_q.size();
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives word transactions into the trie block under several node limits,
// directed cases first and then random words, with random idling on both
// channels, a long receiver hold-off and a drain pause; the checker predicts
// and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STALL_LIMIT    = 150000;
    localparam int PHASE_ITEMS    = 145;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic [2:0]      len;
        logic [4:0][7:0] syms;
    } t_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic       i_opcode = 1'b0;
    logic [7:0] i_symbol = '0;
    logic       i_last_symbol = 1'b0;
    logic       i_empty_word = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [1:0] o_status;
    logic [7:0] o_nodes_used;

    int         err_count;
    int         pending;
    int         items_sent = 0;
    int         in_run = 0;
    int         out_run = 0;
    int         idle_cycles = 0;
    bit         hold_req = 1'b0;
    logic [7:0] sym_pool [4];
    t_word      dict [$];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    trie_insert_lookup_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_symbol      (i_symbol),
        .i_last_symbol (i_last_symbol),
        .i_empty_word  (i_empty_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_nodes_used  (o_nodes_used)
    );

    trie_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_symbol      (i_symbol),
        .i_last_symbol (i_last_symbol),
        .i_empty_word  (i_empty_word),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_status      (o_status),
        .i_nodes_used  (o_nodes_used),
        .o_err_count   (err_count),
        .o_pending     (pending)
    );

    // wait before an item, with occasional runs of back-to-back transactions
    function automatic int pick_wait(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic send_item(input logic op, input logic [7:0] sym,
                             input logic last, input logic empty);
        int w;
        w = pick_wait(in_run);
        @(negedge i_clk);
        if (w > 0) begin
            i_in_valid <= 1'b0;
            repeat (w) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_symbol      <= sym;
        i_last_symbol <= last;
        i_empty_word  <= empty;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic set_node_limit(input logic [7:0] val);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_word();
        t_word w;
        int    r;
        logic  op;
        r = $urandom_range(0, 99);
        if (r < 20 && dict.size() > 0) begin
            w  = dict[$urandom_range(0, dict.size() - 1)];
            op = ($urandom_range(0, 3) == 0);
        end else begin
            w.len = 3'($urandom_range(1, 5));
            for (int i = 0; i < 5; i++)
                w.syms[i] = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                        : sym_pool[$urandom_range(0, 3)];
            op = 1'($urandom_range(0, 1));
            if (op && r < 70) begin
                if (dict.size() < 64) dict.push_back(w);
                else dict[$urandom_range(0, 63)] = w;
            end
        end
        if (r < 80) begin
            for (int i = 0; i < w.len; i++)
                send_item((r >= 70) ? 1'($urandom_range(0, 1)) : op, w.syms[i],
                          (i == w.len - 1), 1'b0);
        end else if (r < 85) begin
            send_item(op, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
            send_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 3) == 0));
        end
    endtask

    // receiver: random wait per result, one long hold-off on request
    initial begin
        int w;
        forever begin
            if (hold_req) begin
                w = HOLD_OFF_CYCLES;
                hold_req = 1'b0;
            end else begin
                w = pick_wait(out_run);
            end
            @(negedge i_clk);
            if (w > 0) begin
                i_out_ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] limits [7];
        int         phase_end;
        bit         mid_done;
        limits = '{8'd12, 8'd30, 8'd60, 8'd100, 8'd128, 8'd255, 8'd5};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no node may be taken: inserts of symbols fail, empty words touch the root
        set_node_limit(8'd0);
        send_item(1'b1, 8'h00, 1'b1, 1'b0);
        send_item(1'b0, 8'h3C, 1'b1, 1'b1);
        send_item(1'b1, 8'hC3, 1'b1, 1'b1);
        send_item(1'b0, 8'h00, 1'b0, 1'b1);
        set_node_limit(8'd1);
        send_item(1'b1, 8'hFF, 1'b1, 1'b0);

        // two free nodes: fill the table, then full and mixed-opcode words
        set_node_limit(8'd3);
        send_item(1'b1, 8'h00, 1'b0, 1'b0);
        send_item(1'b1, 8'hFF, 1'b1, 1'b0);
        send_item(1'b0, 8'h00, 1'b0, 1'b0);
        send_item(1'b0, 8'hFF, 1'b1, 1'b0);
        send_item(1'b0, 8'h00, 1'b1, 1'b0);
        send_item(1'b1, 8'h55, 1'b0, 1'b0);
        send_item(1'b1, 8'hAA, 1'b1, 1'b0);
        send_item(1'b0, 8'h00, 1'b0, 1'b0);
        send_item(1'b1, 8'hFF, 1'b1, 1'b0);
        send_item(1'b1, 8'h00, 1'b0, 1'b0);
        send_item(1'b0, 8'h07, 1'b1, 1'b0);
        send_item(1'b0, 8'h09, 1'b0, 1'b0);
        send_item(1'b1, 8'h01, 1'b1, 1'b0);
        send_item(1'b1, 8'h00, 1'b0, 1'b0);
        send_item(1'b1, 8'hFF, 1'b0, 1'b1);
        send_item(1'b0, 8'h00, 1'b1, 1'b0);
        send_item(1'b1, 8'h00, 1'b0, 1'b0);
        send_item(1'b0, 8'h5A, 1'b1, 1'b1);

        for (int p = 0; p < 7; p++) begin
            set_node_limit(limits[p]);
            for (int i = 0; i < 4; i++) sym_pool[i] = 8'($urandom);
            phase_end = items_sent + PHASE_ITEMS;
            mid_done  = 1'b0;
            while (items_sent < phase_end) begin
                if (!mid_done && items_sent >= phase_end - PHASE_ITEMS / 2) begin
                    mid_done = 1'b1;
                    if (p == 2) hold_req = 1'b1;
                    if (p == 4) begin
                        @(negedge i_clk);
                        i_in_valid <= 1'b0;
                        wait (pending == 0);
                    end
                end
                random_word();
            end
            // close any word left open by a stray transaction
            send_item(1'b0, 8'($urandom), 1'b1, 1'b1);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
